// ----- hdl/hbd_pkg.sv -----
// ----------------------------------------------------------------------------
// hbd_pkg
// shared constants, register codes and coefficient tables for the halfband
// decimator cascade
// ----------------------------------------------------------------------------
package hbd_pkg;

    localparam int HBD_MAX_STAGES   = 4;
    localparam int HBD_MAX_SECTIONS = 6;
    localparam int HBD_SAMPLE_WIDTH = 24;
    localparam int HBD_COEF_WIDTH   = 18;
    localparam int HBD_GUARD_BITS   = 4;
    localparam int HBD_TABLE_FRAC   = 18;

    // register map
    localparam int HBD_PADDR_WIDTH = 4;
    localparam logic [1:0] REG_FILTER_ORDER  = 2'd0;
    localparam logic [1:0] REG_STEEP_MODE    = 2'd1;
    localparam logic [1:0] REG_STAGES_IN_USE = 2'd2;

    localparam logic [3:0] ORDER_RESET  = 4'd2;
    localparam logic       STEEP_RESET  = 1'b0;
    localparam logic [2:0] STAGES_RESET = 3'd1;

    // table index from order: 4,6,8,10,12 pick their own set, others the order-2 set
    function automatic logic [2:0] order_index(input logic [3:0] ord);
        logic [2:0] idx;
        idx = 3'd0;
        if (ord >= 4'd4 && ord <= 4'd12 && ord[0] == 1'b0)
        begin
            idx = 3'(ord[3:1] - 3'd1);
        end
        return idx;
    endfunction

    // Q0.18 allpass coefficients
    function automatic logic [17:0] coef_table(input logic steep, input logic [2:0] oidx,
                                               input logic chain, input logic [2:0] k);
        logic [17:0] c;
        c = 18'd0;
        case ({steep, oidx, chain, k})
            // soft
            {1'b0, 3'd0, 1'b0, 3'd0}: c = 18'd61989;
            {1'b0, 3'd0, 1'b1, 3'd0}: c = 18'd187313;
            {1'b0, 3'd1, 1'b0, 3'd0}: c = 18'd20937;
            {1'b0, 3'd1, 1'b0, 3'd1}: c = 18'd142961;
            {1'b0, 3'd1, 1'b1, 3'd0}: c = 18'd74404;
            {1'b0, 3'd1, 1'b1, 3'd1}: c = 18'd218736;
            {1'b0, 3'd2, 1'b0, 3'd0}: c = 18'd15807;
            {1'b0, 3'd2, 1'b0, 3'd1}: c = 18'd108158;
            {1'b0, 3'd2, 1'b0, 3'd2}: c = 18'd202563;
            {1'b0, 3'd2, 1'b1, 3'd0}: c = 18'd56616;
            {1'b0, 3'd2, 1'b1, 3'd1}: c = 18'd158429;
            {1'b0, 3'd2, 1'b1, 3'd2}: c = 18'd242191;
            {1'b0, 3'd3, 1'b0, 3'd0}: c = 18'd9393;
            {1'b0, 3'd3, 1'b0, 3'd1}: c = 18'd71314;
            {1'b0, 3'd3, 1'b0, 3'd2}: c = 18'd149961;
            {1'b0, 3'd3, 1'b0, 3'd3}: c = 18'd216826;
            {1'b0, 3'd3, 1'b1, 3'd0}: c = 18'd35151;
            {1'b0, 3'd3, 1'b1, 3'd1}: c = 18'd111234;
            {1'b0, 3'd3, 1'b1, 3'd2}: c = 18'd185150;
            {1'b0, 3'd3, 1'b1, 3'd3}: c = 18'd246809;
            {1'b0, 3'd4, 1'b0, 3'd0}: c = 18'd6205;
            {1'b0, 3'd4, 1'b0, 3'd1}: c = 18'd49780;
            {1'b0, 3'd4, 1'b0, 3'd2}: c = 18'd113134;
            {1'b0, 3'd4, 1'b0, 3'd3}: c = 18'd173854;
            {1'b0, 3'd4, 1'b0, 3'd4}: c = 18'd225448;
            {1'b0, 3'd4, 1'b1, 3'd0}: c = 18'd23741;
            {1'b0, 3'd4, 1'b1, 3'd1}: c = 18'd80703;
            {1'b0, 3'd4, 1'b1, 3'd2}: c = 18'd144619;
            {1'b0, 3'd4, 1'b1, 3'd3}: c = 18'd200596;
            {1'b0, 3'd4, 1'b1, 3'd4}: c = 18'd249686;
            {1'b0, 3'd5, 1'b0, 3'd0}: c = 18'd4397;
            {1'b0, 3'd5, 1'b0, 3'd1}: c = 18'd36444;
            {1'b0, 3'd5, 1'b0, 3'd2}: c = 18'd87163;
            {1'b0, 3'd5, 1'b0, 3'd3}: c = 18'd140945;
            {1'b0, 3'd5, 1'b0, 3'd4}: c = 18'd189116;
            {1'b0, 3'd5, 1'b0, 3'd5}: c = 18'd231260;
            {1'b0, 3'd5, 1'b1, 3'd0}: c = 18'd17043;
            {1'b0, 3'd5, 1'b1, 3'd1}: c = 18'd60540;
            {1'b0, 3'd5, 1'b1, 3'd2}: c = 18'd114424;
            {1'b0, 3'd5, 1'b1, 3'd3}: c = 18'd165927;
            {1'b0, 3'd5, 1'b1, 3'd4}: c = 18'd210706;
            {1'b0, 3'd5, 1'b1, 3'd5}: c = 18'd251650;
            // steep
            {1'b1, 3'd0, 1'b0, 3'd0}: c = 18'd61989;
            {1'b1, 3'd0, 1'b1, 3'd0}: c = 18'd187313;
            {1'b1, 3'd1, 1'b0, 3'd0}: c = 18'd31649;
            {1'b1, 3'd1, 1'b0, 3'd1}: c = 18'd173854;
            {1'b1, 3'd1, 1'b1, 3'd0}: c = 18'd102331;
            {1'b1, 3'd1, 1'b1, 3'd1}: c = 18'd233514;
            {1'b1, 3'd2, 1'b0, 3'd0}: c = 18'd33329;
            {1'b1, 3'd2, 1'b0, 3'd1}: c = 18'd171134;
            {1'b1, 3'd2, 1'b0, 3'd2}: c = 18'd240568;
            {1'b1, 3'd2, 1'b1, 3'd0}: c = 18'd105006;
            {1'b1, 3'd2, 1'b1, 3'd1}: c = 18'd215067;
            {1'b1, 3'd2, 1'b1, 3'd2}: c = 18'd255934;
            {1'b1, 3'd3, 1'b0, 3'd0}: c = 18'd20215;
            {1'b1, 3'd3, 1'b0, 3'd1}: c = 18'd126372;
            {1'b1, 3'd3, 1'b0, 3'd2}: c = 18'd208882;
            {1'b1, 3'd3, 1'b0, 3'd3}: c = 18'd246743;
            {1'b1, 3'd3, 1'b1, 3'd0}: c = 18'd69722;
            {1'b1, 3'd3, 1'b1, 3'd1}: c = 18'd174353;
            {1'b1, 3'd3, 1'b1, 3'd2}: c = 18'd231762;
            {1'b1, 3'd3, 1'b1, 3'd3}: c = 18'd257427;
            {1'b1, 3'd4, 1'b0, 3'd0}: c = 18'd13489;
            {1'b1, 3'd4, 1'b0, 3'd1}: c = 18'd94316;
            {1'b1, 3'd4, 1'b0, 3'd2}: c = 18'd176304;
            {1'b1, 3'd4, 1'b0, 3'd3}: c = 18'd225205;
            {1'b1, 3'd4, 1'b0, 3'd4}: c = 18'd250091;
            {1'b1, 3'd4, 1'b1, 3'd0}: c = 18'd48816;
            {1'b1, 3'd4, 1'b1, 3'd1}: c = 18'd138924;
            {1'b1, 3'd4, 1'b1, 3'd2}: c = 18'd204741;
            {1'b1, 3'd4, 1'b1, 3'd3}: c = 18'd239647;
            {1'b1, 3'd4, 1'b1, 3'd4}: c = 18'd258336;
            {1'b1, 3'd5, 1'b0, 3'd0}: c = 18'd9616;
            {1'b1, 3'd5, 1'b0, 3'd1}: c = 18'd71993;
            {1'b1, 3'd5, 1'b0, 3'd2}: c = 18'd147089;
            {1'b1, 3'd5, 1'b0, 3'd3}: c = 18'd201783;
            {1'b1, 3'd5, 1'b0, 3'd4}: c = 18'd233901;
            {1'b1, 3'd5, 1'b0, 3'd5}: c = 18'd252207;
            {1'b1, 3'd5, 1'b1, 3'd0}: c = 18'd35795;
            {1'b1, 3'd5, 1'b1, 3'd1}: c = 18'd110923;
            {1'b1, 3'd5, 1'b1, 3'd2}: c = 18'd177613;
            {1'b1, 3'd5, 1'b1, 3'd3}: c = 18'd220172;
            {1'b1, 3'd5, 1'b1, 3'd4}: c = 18'd244198;
            {1'b1, 3'd5, 1'b1, 3'd5}: c = 18'd258950;
            default: c = 18'd0;
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/hbd_stream_if.sv -----
// ----------------------------------------------------------------------------
// hbd stream interfaces
// valid/ready channels for input and output sample words
// ----------------------------------------------------------------------------
interface hbd_in_if #(parameter int WIDTH = 24);
    logic                     valid;
    logic                     ready;
    logic signed [WIDTH-1:0]  sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface hbd_out_if #(parameter int WIDTH = 24);
    logic                     valid;
    logic                     ready;
    logic signed [WIDTH-1:0]  sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ----- hdl/hbd_smul.sv -----
// ----------------------------------------------------------------------------
// hbd_smul
// bit-serial signed x unsigned multiplier, coefficient one bit per cycle msb
// first, result rounded half up by COEF_WIDTH bits
// ----------------------------------------------------------------------------
module hbd_smul #(
    parameter int DATA_WIDTH = 29,
    parameter int COEF_WIDTH = 18
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DATA_WIDTH-1:0] mcand,
    input  logic        [COEF_WIDTH-1:0] coef,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] product
);
    localparam int AW = DATA_WIDTH + COEF_WIDTH;
    localparam int CW = $clog2(COEF_WIDTH + 1);

    logic signed [AW-1:0]         acc_reg;
    logic signed [DATA_WIDTH-1:0] mcand_reg;
    logic        [COEF_WIDTH-1:0] coef_reg;
    logic        [CW-1:0]         cnt_reg;
    logic                         done_reg;
    logic signed [AW-1:0]         acc_next;
    logic signed [AW-1:0]         rounded;

    always_comb
    begin
        acc_next = acc_reg <<< 1;
        if (coef_reg[COEF_WIDTH-1])
        begin
            acc_next = acc_next + AW'(mcand_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            // last step of the serial multiply
            done_reg <= !start && (cnt_reg == CW'(1));
            if (start)
            begin
                cnt_reg <= CW'(COEF_WIDTH);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg   <= '0;
            mcand_reg <= mcand;
            coef_reg  <= coef;
        end
        else if (cnt_reg != '0)
        begin
            acc_reg  <= acc_next;
            coef_reg <= coef_reg << 1;
        end
    end

    assign rounded = acc_reg + (AW'(1) <<< (COEF_WIDTH - 1));
    assign product = rounded[AW-1:COEF_WIDTH];
    assign done    = done_reg;

endmodule

// ----- hdl/halfband_decimator_cascade.sv -----
// ----------------------------------------------------------------------------
// halfband_decimator_cascade
// cascade of decimate-by-two polyphase iir halfband stages built from two
// chains of second-order allpass sections, one shared bit-serial multiplier
// ----------------------------------------------------------------------------
//
//  channel  | kind       | payload                 | direction
//  ---------+------------+-------------------------+----------
//  din      | valid/rdy  | sample_in  (signed)     | in
//  dout     | valid/rdy  | sample_out (signed)     | out
//  apb      | apb write  | filter_order, steep_mode, stages_in_use | in
//
//  each allpass section steps through read, load, serial multiply and write
//  back; a halfband stage adds one combining step; the pace of words is set
//  by the single shared multiplier and the one-port state memory, and no
//  new input word is taken until the last one is through the cascade
//  after reset and after a write to any of the three listed registers a
//  clearing pass zeroes all 2*MAX_STAGES*MAX_SECTIONS section state words;
//  no word is taken meanwhile
//  a finished word waits in the output register; the next input word is
//  taken while it waits, a second result stalls until the first is taken
//
module halfband_decimator_cascade #(
    parameter int MAX_STAGES   = hbd_pkg::HBD_MAX_STAGES,
    parameter int MAX_SECTIONS = hbd_pkg::HBD_MAX_SECTIONS,
    parameter int SAMPLE_WIDTH = hbd_pkg::HBD_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = hbd_pkg::HBD_COEF_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    hbd_in_if.sink                              din,
    hbd_out_if.source                           dout,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hbd_pkg::HBD_PADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import hbd_pkg::*;

    localparam int IW    = SAMPLE_WIDTH + HBD_GUARD_BITS;   // internal width
    localparam int DEPTH = 2 * MAX_STAGES * MAX_SECTIONS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW    = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int SW    = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int WW    = 4 * IW;
    // coefficient rescale from the Q0.18 tables
    localparam int CSH   = 27 - COEF_WIDTH;
    localparam logic [27:0] CRND = (CSH > 0) ? (28'd1 << (CSH - 1)) : 28'd0;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_RD, ST_LOAD, ST_MUL, ST_WB, ST_HB, ST_FINISH
    } state_t;

    // configuration registers
    logic [3:0] filter_order_reg;
    logic       steep_mode_reg;
    logic [2:0] stages_in_use_reg;
    logic       cfg_wr;

    state_t               state_reg;
    logic [SW-1:0]        stage_reg;
    logic                 chain_reg;
    logic [KW-1:0]        k_reg;
    logic [AW-1:0]        addr_reg;
    logic [AW-1:0]        base_reg;
    logic signed [IW-1:0] x_reg;          // running section input
    logic signed [IW-1:0] xin_reg;        // stage input, reused for chain b
    logic signed [IW-1:0] aout_reg;
    logic signed [IW-1:0] bout_reg;
    logic signed [IW-1:0] dly_b_reg [MAX_STAGES];
    logic [MAX_STAGES-1:0] phase_reg;
    logic                 out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_data_reg;

    // section state memory, word = {in1, in2, out1, out2}
    logic [WW-1:0]        mem [DEPTH];
    logic [WW-1:0]        rdata_reg;
    logic                 mem_we;
    logic [WW-1:0]        mem_wdata;

    logic signed [IW-1:0] in1, in2, out1, out2;
    logic [2:0]           oidx;
    logic [KW-1:0]        k_last;
    logic [SW-1:0]        stage_last;
    logic [27:0]          coef_ext;
    logic [COEF_WIDTH-1:0] coef;
    logic signed [IW:0]   diff;
    logic                 mul_start;
    logic                 mul_done;
    logic signed [IW:0]   prod;
    logic signed [IW+1:0] ysum;
    logic signed [IW-1:0] y;
    logic signed [IW:0]   hsum;
    logic signed [IW-1:0] hb;
    logic signed [SAMPLE_WIDTH-1:0] x_sat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        case (paddr[3:2])
            REG_FILTER_ORDER:  prdata = 32'(filter_order_reg);
            REG_STEEP_MODE:    prdata = 32'(steep_mode_reg);
            REG_STAGES_IN_USE: prdata = 32'(stages_in_use_reg);
            default:           prdata = '0;
        endcase
    end

    // section count and last stage from the registers
    always_comb
    begin
        oidx = order_index(filter_order_reg);
        if (32'(oidx) + 1 > MAX_SECTIONS)
        begin
            k_last = KW'(MAX_SECTIONS - 1);
        end
        else
        begin
            k_last = KW'(oidx);
        end
        if (stages_in_use_reg == 3'd0)
        begin
            stage_last = '0;
        end
        else if (32'(stages_in_use_reg) > MAX_STAGES)
        begin
            stage_last = SW'(MAX_STAGES - 1);
        end
        else
        begin
            stage_last = SW'(stages_in_use_reg - 3'd1);
        end
    end

    assign coef_ext = {10'd0, coef_table(steep_mode_reg, oidx, chain_reg, 3'(k_reg))} << 9;
    assign coef     = COEF_WIDTH'((coef_ext + CRND) >> CSH);

    assign {in1, in2, out1, out2} = rdata_reg;
    assign diff      = (IW+1)'(x_reg) - (IW+1)'(out2);
    assign mul_start = (state_reg == ST_LOAD);

    hbd_smul #(
        .DATA_WIDTH (IW + 1),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_smul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (diff),
        .coef    (coef),
        .done    (mul_done),
        .product (prod)
    );

    // section output, saturated to the internal width
    always_comb
    begin
        ysum = (IW+2)'(in2) + (IW+2)'(prod);
        if (ysum[IW+1:IW-1] == 3'b000 || ysum[IW+1:IW-1] == 3'b111)
        begin
            y = ysum[IW-1:0];
        end
        else
        begin
            y = {ysum[IW+1], {(IW-1){~ysum[IW+1]}}};
        end
    end

    // halfband sum, rounded half up; never leaves the internal range
    assign hsum = (IW+1)'(aout_reg) + (IW+1)'(dly_b_reg[stage_reg]) + (IW+1)'(1);
    assign hb   = hsum[IW:1];

    always_comb
    begin
        if (&x_reg[IW-1:SAMPLE_WIDTH-1] || ~|x_reg[IW-1:SAMPLE_WIDTH-1])
        begin
            x_sat = x_reg[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            x_sat = {x_reg[IW-1], {(SAMPLE_WIDTH-1){~x_reg[IW-1]}}};
        end
    end

    // memory write: zero in the clearing pass, shifted history on write back
    always_comb
    begin
        mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WB);
        mem_wdata = (state_reg == ST_CLEAR) ? '0 : {x_reg, in1, y, out1};
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= mem_wdata;
        end
        rdata_reg <= mem[addr_reg];
    end

    assign din.ready       = (state_reg == ST_IDLE) && !cfg_wr;
    assign dout.valid      = out_valid_reg;
    assign dout.sample_out = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            filter_order_reg  <= ORDER_RESET;
            steep_mode_reg    <= STEEP_RESET;
            stages_in_use_reg <= STAGES_RESET;
            stage_reg         <= '0;
            chain_reg         <= 1'b0;
            k_reg             <= '0;
            addr_reg          <= '0;
            base_reg          <= '0;
            phase_reg         <= '0;
            out_valid_reg     <= 1'b0;
            for (int i = 0; i < MAX_STAGES; i++)
            begin
                dly_b_reg[i] <= '0;
            end
        end
        else
        begin
            // the finish state handles its own handshake
            if (out_valid_reg && dout.ready && (state_reg != ST_FINISH || cfg_wr))
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr && paddr[3:2] inside {REG_FILTER_ORDER, REG_STEEP_MODE,
                                              REG_STAGES_IN_USE})
            begin
                case (paddr[3:2])
                    REG_FILTER_ORDER:  filter_order_reg  <= pwdata[3:0];
                    REG_STEEP_MODE:    steep_mode_reg    <= pwdata[0];
                    REG_STAGES_IN_USE: stages_in_use_reg <= pwdata[2:0];
                    default:           filter_order_reg  <= filter_order_reg;
                endcase
                // a write to any listed register restarts from cleared state
                state_reg <= ST_CLEAR;
                addr_reg  <= '0;
                phase_reg <= '0;
                for (int i = 0; i < MAX_STAGES; i++)
                begin
                    dly_b_reg[i] <= '0;
                end
            end
            else
            begin
                case (state_reg)
                    ST_CLEAR:
                    begin
                        if (addr_reg == AW'(DEPTH - 1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            addr_reg <= addr_reg + 1'b1;
                        end
                    end
                    ST_IDLE:
                    begin
                        if (din.valid)
                        begin
                            x_reg     <= {{HBD_GUARD_BITS{din.sample_in[SAMPLE_WIDTH-1]}},
                                          din.sample_in};
                            xin_reg   <= {{HBD_GUARD_BITS{din.sample_in[SAMPLE_WIDTH-1]}},
                                          din.sample_in};
                            stage_reg <= '0;
                            chain_reg <= 1'b0;
                            k_reg     <= '0;
                            addr_reg  <= '0;
                            base_reg  <= '0;
                            state_reg <= ST_RD;
                        end
                    end
                    ST_RD:
                    begin
                        state_reg <= ST_LOAD;
                    end
                    ST_LOAD:
                    begin
                        state_reg <= ST_MUL;
                    end
                    ST_MUL:
                    begin
                        if (mul_done)
                        begin
                            state_reg <= ST_WB;
                        end
                    end
                    ST_WB:
                    begin
                        if (k_reg == k_last)
                        begin
                            if (!chain_reg)
                            begin
                                // chain a done, run chain b on the same input
                                aout_reg  <= y;
                                chain_reg <= 1'b1;
                                k_reg     <= '0;
                                addr_reg  <= base_reg + AW'(MAX_SECTIONS);
                                x_reg     <= xin_reg;
                                state_reg <= ST_RD;
                            end
                            else
                            begin
                                x_reg     <= y;
                                bout_reg  <= y;
                                state_reg <= ST_HB;
                            end
                        end
                        else
                        begin
                            x_reg     <= y;
                            k_reg     <= k_reg + 1'b1;
                            addr_reg  <= addr_reg + 1'b1;
                            state_reg <= ST_RD;
                        end
                    end
                    ST_HB:
                    begin
                        dly_b_reg[stage_reg] <= bout_reg;
                        phase_reg[stage_reg] <= ~phase_reg[stage_reg];
                        x_reg <= hb;
                        if (!phase_reg[stage_reg])
                        begin
                            // even phase: this stage drops the word
                            state_reg <= ST_IDLE;
                        end
                        else if (stage_reg == stage_last)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            xin_reg   <= hb;
                            stage_reg <= stage_reg + 1'b1;
                            chain_reg <= 1'b0;
                            k_reg     <= '0;
                            base_reg  <= base_reg + AW'(2 * MAX_SECTIONS);
                            addr_reg  <= base_reg + AW'(2 * MAX_SECTIONS);
                            state_reg <= ST_RD;
                        end
                    end
                    ST_FINISH:
                    begin
                        if (!out_valid_reg || dout.ready)
                        begin
                            out_valid_reg <= 1'b1;
                            out_data_reg  <= x_sat;
                            state_reg     <= ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

// ----- tb/tb_halfband_decimator_cascade.sv -----
// ----------------------------------------------------------------------------
// tb_halfband_decimator_cascade
// streams sample words through the halfband decimator cascade under several
// register settings, with random idling on both channels and one long output
// stall, and checks every output word against a bit-true predictor of the
// allpass halfband cascade
// ----------------------------------------------------------------------------
module tb_halfband_decimator_cascade;

    import hbd_pkg::*;

    localparam int NSTG  = HBD_MAX_STAGES;
    localparam int NSEC  = HBD_MAX_SECTIONS;
    localparam int SW    = HBD_SAMPLE_WIDTH;
    localparam int CW    = HBD_COEF_WIDTH;
    localparam int IW    = SW + HBD_GUARD_BITS;
    localparam int NCELL = NSTG * 2 * NSEC;

    // worst word: every stage, six sections per chain
    localparam int WORD_CYCLES = NSTG * (2 * NSEC * (CW + 4) + 1) + 1;
    localparam int DRAIN       = WORD_CYCLES + 2 * NCELL + 200;
    localparam int LONG_HOLD   = 2500;
    localparam int STALL_LIMIT = 40000;

    // q0.18 allpass coefficients [steep][order set][chain][section]
    localparam int unsigned ALLPASS_Q18 [0:1][0:5][0:1][0:5] = '{
        '{
            '{'{61989, 0, 0, 0, 0, 0}, '{187313, 0, 0, 0, 0, 0}},
            '{'{20937, 142961, 0, 0, 0, 0}, '{74404, 218736, 0, 0, 0, 0}},
            '{'{15807, 108158, 202563, 0, 0, 0}, '{56616, 158429, 242191, 0, 0, 0}},
            '{'{9393, 71314, 149961, 216826, 0, 0}, '{35151, 111234, 185150, 246809, 0, 0}},
            '{'{6205, 49780, 113134, 173854, 225448, 0},
              '{23741, 80703, 144619, 200596, 249686, 0}},
            '{'{4397, 36444, 87163, 140945, 189116, 231260},
              '{17043, 60540, 114424, 165927, 210706, 251650}}
        },
        '{
            '{'{61989, 0, 0, 0, 0, 0}, '{187313, 0, 0, 0, 0, 0}},
            '{'{31649, 173854, 0, 0, 0, 0}, '{102331, 233514, 0, 0, 0, 0}},
            '{'{33329, 171134, 240568, 0, 0, 0}, '{105006, 215067, 255934, 0, 0, 0}},
            '{'{20215, 126372, 208882, 246743, 0, 0}, '{69722, 174353, 231762, 257427, 0, 0}},
            '{'{13489, 94316, 176304, 225205, 250091, 0},
              '{48816, 138924, 204741, 239647, 258336, 0}},
            '{'{9616, 71993, 147089, 201783, 233901, 252207},
              '{35795, 110923, 177613, 220172, 244198, 258950}}
        }
    };

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [HBD_PADDR_WIDTH-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    hbd_in_if  #(.WIDTH(SW)) din_if ();
    hbd_out_if #(.WIDTH(SW)) dout_if ();

    halfband_decimator_cascade u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din_if.sink),
        .dout    (dout_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of the registers
    logic [3:0] order_reg;
    logic       steep_reg;
    logic [2:0] stages_reg;

    // predictor copy of the filter state
    longint in_z1 [NCELL];
    longint in_z2 [NCELL];
    longint out_z1 [NCELL];
    longint out_z2 [NCELL];
    longint b_delay [NSTG];
    bit     odd_phase [NSTG];

    logic signed [SW-1:0] sample_feed_q [$];
    logic signed [SW-1:0] decimated_q [$];

    bit errors;
    bit quiet;          // no idling on either side
    bit long_hold_req;  // ask the receiver for one long stall
    bit word_taken;
    int send_gap;
    int recv_hold;
    int stall_cycles;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic longint clip(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // floor((v + half) / 2^s)
    function automatic longint round_down_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic void clear_filter();
        for (int i = 0; i < NCELL; i++)
        begin
            in_z1[i] = 0;
            in_z2[i] = 0;
            out_z1[i] = 0;
            out_z2[i] = 0;
        end
        for (int s = 0; s < NSTG; s++)
        begin
            b_delay[s] = 0;
            odd_phase[s] = 0;
        end
    endfunction

    function automatic longint allpass_chain(input int stg, input int chain, input int oset,
                                             input longint x_in);
        longint x;
        longint a;
        longint p;
        longint y;
        int i;
        x = x_in;
        for (int k = 0; k <= oset; k++)
        begin
            i = (stg * 2 + chain) * NSEC + k;
            a = longint'(ALLPASS_Q18[steep_reg][oset][chain][k]) <<< (CW - HBD_TABLE_FRAC);
            p = round_down_shift((x - out_z2[i]) * a, CW);
            y = clip(in_z2[i] + p, IW);
            in_z2[i] = in_z1[i];
            in_z1[i] = x;
            out_z2[i] = out_z1[i];
            out_z1[i] = y;
            x = y;
        end
        return x;
    endfunction

    // returns 1 when the word completes a full decimation
    function automatic bit decimate_word(input logic signed [SW-1:0] s_in,
                                         output logic signed [SW-1:0] s_out);
        longint v;
        longint a_out;
        int n;
        int oset;
        bit ph;
        v = longint'(s_in);
        s_out = '0;
        n = int'(stages_reg);
        if (n < 1)
            n = 1;
        if (n > NSTG)
            n = NSTG;
        oset = 0;
        if (order_reg >= 4 && order_reg <= 12 && order_reg[0] == 1'b0)
            oset = int'(order_reg) / 2 - 1;
        for (int s = 0; s < n; s++)
        begin
            a_out = allpass_chain(s, 0, oset, v);
            a_out = clip(round_down_shift(a_out + b_delay[s], 1), IW);
            b_delay[s] = allpass_chain(s, 1, oset, v);
            v = a_out;
            ph = odd_phase[s];
            odd_phase[s] = ~ph;
            if (!ph)
                return 1'b0;
        end
        s_out = SW'(clip(v, SW));
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // input side: words are predicted as the block takes them
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic signed [SW-1:0] r;
        if (rst_n && din_if.valid && din_if.ready)
        begin
            word_taken = 1'b1;
            if (decimate_word(din_if.sample_in, r))
                decimated_q.push_back(r);
        end
    end

    // driver: holds a word until taken, idles in random bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (din_if.valid && !word_taken)
            begin
                // keep offering the same word
            end
            else if (send_gap > 0)
            begin
                din_if.valid <= 1'b0;
                send_gap--;
            end
            else if (sample_feed_q.size() > 0)
            begin
                din_if.valid <= 1'b1;
                din_if.sample_in <= sample_feed_q.pop_front();
                if (!quiet && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 9);
            end
            else
                din_if.valid <= 1'b0;
            word_taken = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                recv_hold = LONG_HOLD;
            end
            if (recv_hold > 0)
            begin
                dout_if.ready <= 1'b0;
                recv_hold--;
            end
            else
            begin
                dout_if.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    recv_hold = $urandom_range(1, 9);
            end
        end
    end

    // compare each output word with the oldest prediction
    always @(posedge clk)
    begin
        logic signed [SW-1:0] want;
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            if (decimated_q.size() == 0)
            begin
                $display("%0t: unexpected output word, expected none, actual %0d",
                         $time, dout_if.sample_out);
                errors = 1'b1;
            end
            else
            begin
                want = decimated_q.pop_front();
                if (dout_if.sample_out !== want)
                begin
                    $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                             $time, want, dout_if.sample_out);
                    errors = 1'b1;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either channel and no register access
    always @(posedge clk)
    begin
        if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready) || psel)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // register writes and phase control
    // ------------------------------------------------------------------------
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= HBD_PADDR_WIDTH'(idx) << 2;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // the block takes the write at this edge
        case (idx)
            REG_FILTER_ORDER:  order_reg = value[3:0];
            REG_STEEP_MODE:    steep_reg = value[0];
            REG_STAGES_IN_USE: stages_reg = value[2:0];
            default: ;
        endcase
        if (idx == REG_FILTER_ORDER || idx == REG_STEEP_MODE || idx == REG_STAGES_IN_USE)
            clear_filter();
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_filter(input logic [31:0] ord, input logic [31:0] steep,
                              input logic [31:0] stg);
        reg_write(REG_FILTER_ORDER, ord);
        reg_write(REG_STEEP_MODE, steep);
        reg_write(REG_STAGES_IN_USE, stg);
    endtask

    // random sample words: mostly full range, some extremes and small values
    task automatic queue_random_words(input int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                sample_feed_q.push_back({1'b0, {(SW-1){1'b1}}});
            else if (pick == 1)
                sample_feed_q.push_back({1'b1, {(SW-1){1'b0}}});
            else if (pick == 2)
                sample_feed_q.push_back(SW'($signed($urandom_range(0, 512)) - 256));
            else
                sample_feed_q.push_back(SW'($urandom));
        end
    endtask

    // wait until every word is in and every result out, then let the block settle
    task automatic wait_idle();
        wait (sample_feed_q.size() == 0 && !din_if.valid && decimated_q.size() == 0);
        repeat (DRAIN) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        din_if.valid = 1'b0;
        din_if.sample_in = '0;
        dout_if.ready = 1'b0;
        errors = 1'b0;
        quiet = 1'b0;
        long_hold_req = 1'b0;
        word_taken = 1'b0;
        send_gap = 0;
        recv_hold = 0;
        stall_cycles = 0;
        order_reg = ORDER_RESET;
        steep_reg = STEEP_RESET;
        stages_reg = STAGES_RESET;
        clear_filter();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words at reset settings: extremes, steps and full-scale swings
        sample_feed_q.push_back('0);
        sample_feed_q.push_back({1'b0, {(SW-1){1'b1}}});
        sample_feed_q.push_back({1'b1, {(SW-1){1'b0}}});
        sample_feed_q.push_back('1);
        sample_feed_q.push_back(SW'(1));
        for (int n = 0; n < 12; n++)
            sample_feed_q.push_back(n[0] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}});
        for (int n = 0; n < 6; n++)
            sample_feed_q.push_back({1'b1, {(SW-1){1'b0}}});
        wait_idle();

        // write beyond the register list: ignored, state kept
        reg_write(2'd3, 32'hFFFF_FFFF);

        // two stages, long output stall while words keep coming
        set_filter(32'd4, 32'd1, 32'd2);
        queue_random_words(200);
        repeat (300) @(posedge clk);
        long_hold_req = 1'b1;
        wait_idle();

        // highest order, all stages
        set_filter(32'd12, 32'd0, 32'd4);
        queue_random_words(60);
        wait_idle();

        // unlisted order with upper bits set, stage count zero acts as one
        set_filter(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        queue_random_words(150);
        wait_idle();

        // odd order falls back to the order-2 set, three stages
        set_filter(32'd7, 32'hFFFF_FFFE, 32'd3);
        queue_random_words(150);
        wait_idle();

        // stage count above the maximum acts as the maximum
        set_filter(32'd6, 32'd1, 32'd7);
        queue_random_words(100);
        wait_idle();

        set_filter(32'd10, 32'd1, 32'd1);
        queue_random_words(100);
        wait_idle();

        // last part runs without idling
        set_filter(32'd8, 32'd0, 32'd2);
        quiet = 1'b1;
        queue_random_words(150);
        wait_idle();

        if (errors)
            $display("Some tests failed");
        else
            $display("All tests passed");
        $finish;
    end

endmodule
